>>> rtl/core/fspd_pkg.sv
// ----------------------------------------------------------------------------
// fspd_pkg
// Types, widths and fixed-point constants shared by the flow-scheduled
// pressure deadband controller.
// ----------------------------------------------------------------------------
package fspd_pkg;

  // Field widths
  localparam int CUR_W       = 15;  // loop current, microamps
  localparam int FLOW_W      = 16;  // converted flow
  localparam int PRESS_W     = 9;   // converted pressure, hundredths
  localparam int SETP_W      = 16;  // pressure setpoint
  localparam int CMD_W       = 2;   // valve command
  localparam int TOL_W       = 10;  // deadband half width
  localparam int ENTRY_W     = 40;  // packed table entry
  localparam int MAXF_W      = 24;  // maximum flow field of an entry
  localparam int REG_INDEX_W = 4;   // register index on the config channel

  // Table
  localparam int TABLE_ENTRIES_DEF = 7;
  localparam int TABLE_ENTRIES_MAX = 7;
  localparam logic [MAXF_W-1:0]  MAXF_NONE  = '1;
  localparam logic [SETP_W-1:0]  SETP_NONE  = '1;
  localparam logic [ENTRY_W-1:0] ENTRY_RST  = '1;
  localparam logic [TOL_W-1:0]   TOL_RST    = TOL_W'(10);

  // Register map
  localparam logic [REG_INDEX_W-1:0] REG_TOLERANCE  = REG_INDEX_W'(0);
  localparam int                     REG_ENTRY_BASE = 1;

  // Loop floor: 4 mA
  localparam logic [CUR_W-1:0] LOOP_MIN_UA = CUR_W'(4000);

  // Flow: q = (2469*uA - 9406000) / 100000, flow = min(q*100, 65535)
  localparam int NUM_W       = 27;
  localparam logic [NUM_W-1:0] FLOW_GAIN   = NUM_W'(2469);
  localparam logic [NUM_W-1:0] FLOW_OFFSET = NUM_W'(9406000);
  // floor(N/100000) = (N * ceil(2^44/100000)) >> 44, exact for N < 2^27
  localparam int FRECIP_W    = 28;
  localparam logic [FRECIP_W-1:0] FLOW_RECIP = FRECIP_W'(175921861);
  localparam int FLOW_SHIFT  = 44;
  localparam int QUOT_W      = 10;  // q stays at or below 714
  localparam int FSCALE_W    = FLOW_W + 1;
  localparam logic [FSCALE_W-1:0] FLOW_SCALE = FSCALE_W'(100);

  // Pressure: (uA - 4000) / 80 = ((uA - 4000) >> 4) / 5
  localparam int PDIV_W      = 11;
  localparam int PRECIP_W    = 11;
  // floor(y/5) = (y * ceil(2^13/5)) >> 13, exact for y < 2^11
  localparam logic [PRECIP_W-1:0] PRESS_RECIP = PRECIP_W'(1639);
  localparam int PRESS_SHIFT = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_HOLD  = 2'd0,
    CMD_RAISE = 2'd1,
    CMD_LOWER = 2'd2,
    CMD_NONE  = 2'd3
  } valve_cmd_t;

  // Channel payloads
  typedef struct packed {
    logic [CUR_W-1:0] flow_current;
    logic [CUR_W-1:0] pressure_current;
    logic             readings_ok;
  } sample_t;

  typedef struct packed {
    logic [FLOW_W-1:0]  flow_value;
    logic [PRESS_W-1:0] pressure_value;
    logic [SETP_W-1:0]  setpoint;
    logic [CMD_W-1:0]   valve_command;
  } result_t;

  typedef struct packed {
    logic [REG_INDEX_W-1:0] index;
    logic [ENTRY_W-1:0]     data;
  } cfg_write_t;

  // Pipeline stage contents
  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [PDIV_W-1:0] pdiv;
    logic              ok;
  } stage_num_t;

  typedef struct packed {
    logic [QUOT_W-1:0]  quot;
    logic [PRESS_W-1:0] pressure;
    logic               ok;
  } stage_quot_t;

  typedef struct packed {
    logic [FLOW_W-1:0]  flow_value;
    logic [PRESS_W-1:0] pressure_value;
    logic               ok;
  } conv_t;

endpackage

>>> rtl/core/fspd_stream_if.sv
// ----------------------------------------------------------------------------
// fspd_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface fspd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/core/fspd_cfg_regs.sv
// ----------------------------------------------------------------------------
// fspd_cfg_regs
// Deadband tolerance and schedule table registers.
// ----------------------------------------------------------------------------
module fspd_cfg_regs #(
  parameter int TableEntries = fspd_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        wr_valid,
  output logic                                        wr_ready,
  input  fspd_pkg::cfg_write_t                        wr,
  output logic [fspd_pkg::TOL_W-1:0]                  tolerance,
  output logic [TableEntries-1:0][fspd_pkg::ENTRY_W-1:0] entry
);
  import fspd_pkg::*;

  logic wr_fire;

  assign wr_ready = 1'b1;
  assign wr_fire  = wr_valid;

  // Indexes beyond the table fall through and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RST;
      for (int i = 0; i < TableEntries; i++) begin
        entry[i] <= ENTRY_RST;
      end
    end else if (wr_fire) begin
      if (wr.index == REG_TOLERANCE) begin
        tolerance <= wr.data[TOL_W-1:0];
      end
      for (int i = 0; i < TableEntries; i++) begin
        if (wr.index == REG_INDEX_W'(REG_ENTRY_BASE + i)) begin
          entry[i] <= wr.data;
        end
      end
    end
  end

endmodule

>>> rtl/core/fspd_convert.sv
// ----------------------------------------------------------------------------
// fspd_convert
// Three-stage fixed-point conversion of loop currents to flow and pressure.
// ----------------------------------------------------------------------------
module fspd_convert (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fspd_pkg::sample_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output fspd_pkg::conv_t   out_item
);
  import fspd_pkg::*;

  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3;
  stage_num_t  s1, s1_next;
  stage_quot_t s2, s2_next;
  conv_t       s3, s3_next;

  logic [CUR_W-1:0]             pdiff;
  logic [NUM_W+FRECIP_W-1:0]    fprod;
  logic [PDIV_W+PRECIP_W-1:0]   pprod;
  logic [FSCALE_W-1:0]          fscaled;

  // Each stage moves when it is empty or its successor moves
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Stage 1: linear term of flow, coarse shift of pressure
  always_comb begin
    pdiff   = in_item.pressure_current - LOOP_MIN_UA;
    s1_next = '0;
    s1_next.ok = in_item.readings_ok;
    if (in_item.readings_ok && in_item.flow_current >= LOOP_MIN_UA) begin
      s1_next.num = NUM_W'(in_item.flow_current) * FLOW_GAIN - FLOW_OFFSET;
    end
    if (in_item.readings_ok && in_item.pressure_current >= LOOP_MIN_UA) begin
      s1_next.pdiv = pdiff[CUR_W-1:4];
    end
  end

  // Stage 2: reciprocal multiplies stand in for the constant divides
  always_comb begin
    fprod = (NUM_W+FRECIP_W)'(s1.num) * (NUM_W+FRECIP_W)'(FLOW_RECIP);
    pprod = (PDIV_W+PRECIP_W)'(s1.pdiv) * (PDIV_W+PRECIP_W)'(PRESS_RECIP);
    s2_next.quot     = fprod[FLOW_SHIFT +: QUOT_W];
    s2_next.pressure = pprod[PRESS_SHIFT +: PRESS_W];
    s2_next.ok       = s1.ok;
  end

  // Stage 3: scale flow back up and saturate
  always_comb begin
    fscaled = FSCALE_W'(s2.quot) * FLOW_SCALE;
    s3_next.flow_value     = fscaled[FSCALE_W-1] ? '1 : fscaled[FLOW_W-1:0];
    s3_next.pressure_value = s2.pressure;
    s3_next.ok             = s2.ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= s1_next;
    if (rdy2) s2 <= s2_next;
    if (rdy3) s3 <= s3_next;
  end

  assign out_valid = v3;
  assign out_item  = s3;

endmodule

>>> rtl/core/fspd_schedule.sv
// ----------------------------------------------------------------------------
// fspd_schedule
// Table lookup of the pressure setpoint and deadband decision; holds the
// result register.
// ----------------------------------------------------------------------------
module fspd_schedule #(
  parameter int TableEntries = fspd_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  fspd_pkg::conv_t                                in_item,
  input  logic [fspd_pkg::TOL_W-1:0]                     tolerance,
  input  logic [TableEntries-1:0][fspd_pkg::ENTRY_W-1:0] entry,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output fspd_pkg::result_t                              out_item
);
  import fspd_pkg::*;

  logic               found;
  logic [SETP_W-1:0]  setp;
  logic [MAXF_W-1:0]  maxf;
  logic [SETP_W-1:0]  pv;
  logic [SETP_W:0]    setp_hi;
  logic [SETP_W:0]    press_hi;
  result_t            res_next;
  logic               ov;

  // Lowest matching index wins: scan downward so it is assigned last
  always_comb begin
    found = 1'b0;
    setp  = '0;
    maxf  = '0;
    pv    = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      maxf = entry[i][ENTRY_W-1 -: MAXF_W];
      pv   = entry[i][SETP_W-1:0];
      if (maxf != MAXF_NONE && pv != SETP_NONE &&
          MAXF_W'(in_item.flow_value) <= maxf) begin
        found = 1'b1;
        setp  = pv;
      end
    end
  end

  // setp - tol > p  <=>  setp > p + tol;  setp + tol < p
  always_comb begin
    setp_hi  = (SETP_W+1)'(setp) + (SETP_W+1)'(tolerance);
    press_hi = (SETP_W+1)'(in_item.pressure_value) + (SETP_W+1)'(tolerance);
    res_next.flow_value     = in_item.flow_value;
    res_next.pressure_value = in_item.pressure_value;
    res_next.setpoint       = '0;
    res_next.valve_command  = CMD_NONE;
    if (in_item.ok && found) begin
      res_next.setpoint = setp;
      if ((SETP_W+1)'(setp) > press_hi) begin
        res_next.valve_command = CMD_RAISE;
      end else if (setp_hi < (SETP_W+1)'(in_item.pressure_value)) begin
        res_next.valve_command = CMD_LOWER;
      end else begin
        res_next.valve_command = CMD_HOLD;
      end
    end
  end

  assign in_ready = !ov || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (in_ready) begin
      ov <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) out_item <= res_next;
  end

  assign out_valid = ov;

endmodule

>>> rtl/core/flow_scheduled_pressure_deadband.sv
// ----------------------------------------------------------------------------
// flow_scheduled_pressure_deadband
// Flow-scheduled pressure controller with a tolerance deadband.
// ----------------------------------------------------------------------------
// Each item on the sample channel is one pair of 4-20 mA loop readings in
// microamps plus a readings_ok flag, and yields exactly one result item in
// order. The block is a four-stage pipeline: it takes one item per clock
// while the result channel keeps up. Each accepted item passes through the
// three conversion registers and the result register. Stalls on the result
// side back up stage by stage, so empty stages are filled before the sample
// channel is held off. Flow is
// floor(24.69*mA - 94.06)*100 saturated at 65535, pressure is floor((uA -
// 4000)/80) in hundredths, both 0 below 4 mA. The first table entry (of the
// first TableEntries) that is not marked empty and whose maximum flow covers
// the measured flow gives the setpoint; the command is raise below
// setpoint - tolerance, lower above setpoint + tolerance, else hold. Bad
// readings, or no matching entry, give command 3 (no action) and setpoint 0.
// Write configuration only while no item is in flight; the config channel is
// always ready and writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module flow_scheduled_pressure_deadband #(
  parameter int TableEntries = fspd_pkg::TABLE_ENTRIES_DEF
) (
  input logic           clk,
  input logic           rst,
  fspd_stream_if.sink   sample,
  fspd_stream_if.source result,
  fspd_stream_if.sink   cfg
);
  import fspd_pkg::*;

  logic [TOL_W-1:0]                     tolerance;
  logic [TableEntries-1:0][ENTRY_W-1:0] entry;

  logic  conv_valid;
  logic  conv_ready;
  conv_t conv_item;

  // Configuration registers
  fspd_cfg_regs #(
    .TableEntries (TableEntries)
  ) u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .wr_valid  (cfg.valid),
    .wr_ready  (cfg.ready),
    .wr        (cfg.payload),
    .tolerance (tolerance),
    .entry     (entry)
  );

  // Stages 1-3: current to flow and pressure
  fspd_convert u_convert (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_item   (sample.payload),
    .out_valid (conv_valid),
    .out_ready (conv_ready),
    .out_item  (conv_item)
  );

  // Stage 4: setpoint lookup, deadband, result register
  fspd_schedule #(
    .TableEntries (TableEntries)
  ) u_schedule (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (conv_valid),
    .in_ready  (conv_ready),
    .in_item   (conv_item),
    .tolerance (tolerance),
    .entry     (entry),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_item  (result.payload)
  );

`ifndef NO_ASSERTIONS
  // No action always reports a zero setpoint
  a_none_zero_setp: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.valve_command == CMD_NONE
      |-> result.payload.setpoint == '0)
    else $error("no-action result with nonzero setpoint");

  // Hold means the pressure sits inside the deadband
  a_hold_in_band: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.valve_command == CMD_HOLD
      |-> ((SETP_W+1)'(result.payload.setpoint) <=
           (SETP_W+1)'(result.payload.pressure_value) + (SETP_W+1)'(tolerance))
       && ((SETP_W+1)'(result.payload.pressure_value) <=
           (SETP_W+1)'(result.payload.setpoint) + (SETP_W+1)'(tolerance)))
    else $error("hold command outside deadband");

  // Input is held off only when the result register is full and stalled
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> result.valid && !result.ready)
    else $error("sample channel stalled without a downstream stall");
`endif

endmodule
